>>> src/msb_first_bit_reader_macros.svh
// assertion helpers for the bit reader, compiled out for synthesis
`ifndef MSB_FIRST_BIT_READER_MACROS_SVH
`define MSB_FIRST_BIT_READER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define MSBR_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bit reader check failed");

// next-cycle implication
`define MSBR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bit reader check failed");

`else

`define MSBR_ASSERT_NOW(lbl, pre, post)
`define MSBR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

>>> src/msbr_pkg.sv
package msbr_pkg;

    localparam int BUFFER_BYTES_DEF  = 4096;
    localparam int MAX_READ_BITS_DEF = 64;

    localparam int CURSOR_W = 16;
    localparam int COUNT_W  = 7;
    localparam int ITEMS_W  = 4;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_SEEK_ABS = 3'd1,
        OP_SEEK_REL = 3'd2,
        OP_SEEK_END = 3'd3,
        OP_READ     = 3'd4,
        OP_PEEK     = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH0,
        ST_FETCH1,
        ST_EMIT
    } state_t;

    // byte alignment controls for one output beat
    typedef struct packed {
        logic [2:0] shift;
        logic [2:0] rem;
        logic       tail;
        logic       whole_nz;
    } align_t;

endpackage

>>> src/msbr_store.sv
module msbr_store #(
    parameter int DEPTH  = msbr_pkg::BUFFER_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/msbr_align.sv
module msbr_align (
    input  logic             [7:0] hi,
    input  logic             [7:0] lo,
    input  msbr_pkg::align_t       ctl,
    output logic             [7:0] byte_out
);

    logic [15:0] win;
    logic [7:0]  raw;
    logic [3:0]  pad;
    logic [7:0]  mask;

    always_comb
    begin
        win  = {hi, lo} << ctl.shift;
        raw  = win[15:8];
        pad  = 4'd8 - {1'b0, ctl.rem};
        mask = 8'hff << pad;
        if (ctl.tail && (ctl.rem != 3'd0))
        begin
            // partial tail: left-aligned after whole bytes, else right-aligned
            if (ctl.whole_nz)
            begin
                byte_out = raw & mask;
            end
            else
            begin
                byte_out = raw >> pad;
            end
        end
        else
        begin
            byte_out = raw;
        end
    end

endmodule

>>> src/msb_first_bit_reader.sv
// msb_first_bit_reader: msb-first bitstream reader over a byte store
//
// input channel (in_valid / in_ready) takes one item per beat: load a byte,
// seek the bit cursor (absolute, relative, from end) or read / peek up to
// MAX_READ_BITS bits. output channel (out_valid / out_ready) gives one beat
// per extracted byte of a read or peek that delivers bits, or a single status
// beat for any other item; last marks the final beat of an item.
// cfg_we / cfg_data write the stream length in bits; the user must do so
// only while idle, as the block itself does not enforce it.
// sequence: an item is latched while in_ready is high and then executed, and
// a status item is answered from the execute step. a read delivering k beats
// goes through latch, execute, two store reads to prime the byte window
// (FETCH0, FETCH1), then one beat per cycle while the receiver takes them.
// the store's read is registered, so one stored byte is fetched per beat.
// in_ready is high only between items; one item is worked at a time.
// a finished beat sits in the output register, so a stalled receiver only
// holds the sequencer when the next beat is ready to replace it.
// reset clears cursor, end flag, stream length and out_valid; the
// byte store is not cleared and must be loaded before it is read.
`include "msb_first_bit_reader_macros.svh"

module msb_first_bit_reader #(
    parameter int BUFFER_BYTES  = msbr_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_READ_BITS = msbr_pkg::MAX_READ_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [11:0] byte_address,
    input  logic [7:0]  data_byte,
    input  logic signed [16:0] bit_offset,
    input  logic [6:0]  bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [6:0]  bits_read,
    output logic        at_end,
    output logic        seek_error,
    output logic        last
);

    // store takes low address bits: keep the depth a power of two (not enforced)
    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CW     = msbr_pkg::CURSOR_W;
    localparam int NW     = msbr_pkg::COUNT_W;
    localparam int IW     = msbr_pkg::ITEMS_W;

    msbr_pkg::state_t state_reg, state_next;

    // architectural state
    logic [CW-1:0] stream_bits_reg;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic          end_reg, end_next;

    // latched item
    logic [2:0]         op_reg;
    logic [11:0]        addr_reg;
    logic [7:0]         data_reg;
    logic signed [16:0] off_reg;
    logic [NW-1:0]      count_reg;

    // read context
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]        hi_reg, hi_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [IW-1:0]     items_left_reg, items_left_next;
    logic [2:0]        rem_reg, rem_next;
    logic [2:0]        shift_reg, shift_next;
    logic              whole_nz_reg, whole_nz_next;
    logic              e_reg, e_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [6:0] bits_read_reg, bits_read_next;
    logic       at_end_reg, at_end_next;
    logic       seek_error_reg, seek_error_next;
    logic       last_reg, last_next;
    logic       out_load;
    logic       out_free;

    // store port
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic              st_re;
    logic [ADDR_W-1:0] st_raddr;
    logic [7:0]        st_rdata;

    // execute-cycle arithmetic
    logic [CW-1:0]      left;
    logic [NW-1:0]      req;
    logic [NW-1:0]      n_clip;
    logic [CW-1:0]      rd_sum;
    logic               rd_end;
    logic               abs_bad;
    logic signed [17:0] seek_base;
    logic [CW-1:0]      seek_cur;
    logic [ADDR_W+12:0] start_wide;
    logic [ADDR_W+11:0] load_wide;
    logic [IW-1:0]      items_calc;

    msbr_pkg::align_t ctl;
    logic [7:0]       aligned_byte;

    msbr_store #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (data_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign ctl.shift    = shift_reg;
    assign ctl.rem      = rem_reg;
    assign ctl.tail     = (items_left_reg == IW'(1));
    assign ctl.whole_nz = whole_nz_reg;

    msbr_align u_align (
        .hi       (hi_reg),
        .lo       (st_rdata),
        .ctl      (ctl),
        .byte_out (aligned_byte)
    );

    assign in_ready = (state_reg == msbr_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // clipping, cursor and seek arithmetic for the latched item
    always_comb
    begin
        left = (stream_bits_reg > cursor_reg) ? (stream_bits_reg - cursor_reg) : '0;
        req  = (count_reg > NW'(MAX_READ_BITS)) ? NW'(MAX_READ_BITS) : count_reg;
        // left below req means left fits the count width
        n_clip = ({{(CW-NW){1'b0}}, req} > left) ? left[NW-1:0] : req;
        rd_sum = cursor_reg + {{(CW-NW){1'b0}}, n_clip};
        rd_end = (rd_sum >= stream_bits_reg);

        abs_bad = off_reg[16] || (off_reg[15:0] >= stream_bits_reg);

        if (op_reg == msbr_pkg::OP_SEEK_REL)
        begin
            seek_base = $signed({2'b00, cursor_reg}) + $signed({off_reg[16], off_reg});
        end
        else
        begin
            seek_base = $signed({2'b00, stream_bits_reg}) - $signed({off_reg[16], off_reg});
        end
        // clamp at zero, saturate at the cursor range
        if (seek_base[17])
        begin
            seek_cur = '0;
        end
        else if (seek_base[16])
        begin
            seek_cur = '1;
        end
        else
        begin
            seek_cur = seek_base[15:0];
        end

        start_wide = {{ADDR_W{1'b0}}, cursor_reg[15:3]};
        load_wide  = {{ADDR_W{1'b0}}, addr_reg};
        items_calc = IW'(n_clip[NW-1:3]) + IW'(n_clip[2:0] != 3'd0);
    end

    // sequencer: next state, store access and output beat
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        end_next        = end_reg;
        ptr_next        = ptr_reg;
        hi_next         = hi_reg;
        n_next          = n_reg;
        items_left_next = items_left_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        whole_nz_next   = whole_nz_reg;
        e_next          = e_reg;

        st_we    = 1'b0;
        st_waddr = load_wide[ADDR_W-1:0];
        st_re    = 1'b0;
        st_raddr = ptr_reg;

        out_load        = 1'b0;
        out_byte_next   = '0;
        bits_read_next  = '0;
        at_end_next     = end_reg;
        seek_error_next = 1'b0;
        last_next       = 1'b1;

        unique case (state_reg)
            msbr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = msbr_pkg::ST_EXEC;
                end
            end

            msbr_pkg::ST_EXEC:
            begin
                if (((op_reg == msbr_pkg::OP_READ) || (op_reg == msbr_pkg::OP_PEEK))
                    && !end_reg && (n_clip != '0))
                begin
                    // bits to deliver: set up the byte window walk
                    if (op_reg == msbr_pkg::OP_READ)
                    begin
                        cursor_next = rd_sum;
                        end_next    = rd_end;
                        e_next      = rd_end;
                    end
                    else
                    begin
                        e_next = end_reg;
                    end
                    n_next          = n_clip;
                    items_left_next = items_calc;
                    rem_next        = n_clip[2:0];
                    shift_next      = cursor_reg[2:0];
                    whole_nz_next   = (n_clip[NW-1:3] != '0);
                    ptr_next        = start_wide[ADDR_W-1:0];
                    state_next      = msbr_pkg::ST_FETCH0;
                end
                else if (out_free)
                begin
                    // single status beat
                    out_load   = 1'b1;
                    state_next = msbr_pkg::ST_IDLE;
                    unique case (op_reg) inside
                        msbr_pkg::OP_LOAD:
                        begin
                            st_we = 1'b1;
                        end
                        msbr_pkg::OP_SEEK_ABS:
                        begin
                            if (abs_bad)
                            begin
                                seek_error_next = 1'b1;
                            end
                            else
                            begin
                                cursor_next = off_reg[15:0];
                                end_next    = 1'b0;
                                at_end_next = 1'b0;
                            end
                        end
                        msbr_pkg::OP_SEEK_REL, msbr_pkg::OP_SEEK_END:
                        begin
                            cursor_next = seek_cur;
                            end_next    = (seek_cur >= stream_bits_reg);
                            at_end_next = (seek_cur >= stream_bits_reg);
                        end
                        msbr_pkg::OP_READ:
                        begin
                            // nothing delivered, the end flag still updates
                            if (!end_reg)
                            begin
                                end_next    = (cursor_reg >= stream_bits_reg);
                                at_end_next = (cursor_reg >= stream_bits_reg);
                            end
                        end
                        default:
                        begin
                            // peek with nothing to give, unused codes
                        end
                    endcase
                end
            end

            msbr_pkg::ST_FETCH0:
            begin
                st_re      = 1'b1;
                ptr_next   = ptr_reg + ADDR_W'(1);
                state_next = msbr_pkg::ST_FETCH1;
            end

            msbr_pkg::ST_FETCH1:
            begin
                hi_next    = st_rdata;
                st_re      = 1'b1;
                ptr_next   = ptr_reg + ADDR_W'(1);
                state_next = msbr_pkg::ST_EMIT;
            end

            msbr_pkg::ST_EMIT:
            begin
                out_byte_next  = aligned_byte;
                bits_read_next = n_reg;
                at_end_next    = e_reg;
                last_next      = (items_left_reg == IW'(1));
                if (out_free)
                begin
                    out_load        = 1'b1;
                    items_left_next = items_left_reg - IW'(1);
                    if (items_left_reg == IW'(1))
                    begin
                        state_next = msbr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // slide the window by one stored byte
                        hi_next  = st_rdata;
                        st_re    = 1'b1;
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = msbr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= msbr_pkg::ST_IDLE;
            stream_bits_reg <= '0;
            cursor_reg      <= '0;
            end_reg         <= 1'b0;
            items_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            end_reg        <= end_next;
            items_left_reg <= items_left_next;
            if (cfg_we)
            begin
                stream_bits_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= opcode;
            addr_reg  <= byte_address;
            data_reg  <= data_byte;
            off_reg   <= bit_offset;
            count_reg <= bit_count;
        end
        ptr_reg      <= ptr_next;
        hi_reg       <= hi_next;
        n_reg        <= n_next;
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        whole_nz_reg <= whole_nz_next;
        e_reg        <= e_next;
        if (out_load)
        begin
            out_byte_reg   <= out_byte_next;
            bits_read_reg  <= bits_read_next;
            at_end_reg     <= at_end_next;
            seek_error_reg <= seek_error_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign bits_read  = bits_read_reg;
    assign at_end     = at_end_reg;
    assign seek_error = seek_error_reg;
    assign last       = last_reg;

    // a byte walk always has beats left to give
    `MSBR_ASSERT_NOW(a_emit_has_items, state_reg == msbr_pkg::ST_EMIT, items_left_reg != '0)
    // a beat that is not the final one belongs to a read that delivered bits
    `MSBR_ASSERT_NOW(a_mid_beat_has_bits, out_valid && !last, bits_read != '0)
    // the final beat of a byte walk returns the sequencer to idle
    `MSBR_ASSERT_NEXT(a_walk_ends_idle,
        state_reg == msbr_pkg::ST_EMIT && out_load && items_left_reg == IW'(1),
        state_reg == msbr_pkg::ST_IDLE && out_valid_reg && last_reg)

endmodule
